>>> rtl/rgb_window_median_filter_defines.svh
// Assertion macros for the RGB window median filter.
// Included by the RTL files that carry assertions; no dependencies.
`ifndef RGB_WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define RGB_WINDOW_MEDIAN_FILTER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RWMF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define RWMF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/rwmf_pkg.sv
// Shared types and constants of the RGB window median filter.
// No dependencies.
package rwmf_pkg;

  localparam int unsigned MaxWidth     = 1024;
  localparam int unsigned MaxHalfWidth = 3;
  localparam int unsigned LineRows     = 2 * MaxHalfWidth + 2;
  localparam int unsigned ColW         = $clog2(MaxWidth);
  localparam int unsigned RowSelW      = $clog2(LineRows);
  localparam int unsigned AddrW        = ColW + RowSelW;
  localparam int unsigned PixW         = 24;
  localparam int unsigned CntW         = 6;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegHalf   = 2'd2;

  localparam logic CmdPixel = 1'b0;

  // control from the sequencer to each rank selector
  typedef struct packed {
    logic       init;
    logic [2:0] bit_idx;
    logic       data_vld;
    logic       data_last;
  } sel_ctl_t;

endpackage

>>> rtl/rwmf_line_mem.sv
// Line store: one write port, one read port, registered read data.
// Depends on rwmf_pkg.
module rwmf_line_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [rwmf_pkg::AddrW-1:0]  waddr_i,
  input  logic [rwmf_pkg::PixW-1:0]   wdata_i,
  input  logic [rwmf_pkg::AddrW-1:0]  raddr_i,
  output logic [rwmf_pkg::PixW-1:0]   rdata_o
);

  logic [rwmf_pkg::PixW-1:0] mem [rwmf_pkg::MaxWidth*rwmf_pkg::LineRows];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> rtl/rwmf_rank_sel.sv
// Bitwise rank selector: finds the value of given rank among a stream,
// one bit per pass over the window, MSB first. Depends on rwmf_pkg.
module rwmf_rank_sel (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rwmf_pkg::sel_ctl_t           ctl_i,
  input  logic [rwmf_pkg::CntW-1:0]    rank_i,
  input  logic [7:0]                   val_i,
  output logic [7:0]                   result_o
);

  logic [rwmf_pkg::CntW-1:0] k_q, k_d, cnt_q, cnt_d, cnt_tot;
  logic [7:0]                p_q, p_d, mask;
  logic                      match;

  assign mask    = 8'hFF << ctl_i.bit_idx;
  assign match   = (val_i & mask) == p_q;
  assign cnt_tot = cnt_q + rwmf_pkg::CntW'(match);

  always_comb begin
    k_d   = k_q;
    p_d   = p_q;
    cnt_d = cnt_q;
    if (ctl_i.init) begin
      k_d   = rank_i;
      p_d   = '0;
      cnt_d = '0;
    end else if (ctl_i.data_vld) begin
      cnt_d = cnt_tot;
      if (ctl_i.data_last) begin
        cnt_d = '0;
        // fewer than rank+1 values below: the bit is one
        if (k_q >= cnt_tot) begin
          p_d = p_q | (8'd1 << ctl_i.bit_idx);
          k_d = k_q - cnt_tot;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      p_q   <= '0;
      cnt_q <= '0;
    end else begin
      k_q   <= k_d;
      p_q   <= p_d;
      cnt_q <= cnt_d;
    end
  end

  assign result_o = p_q;

endmodule

>>> rtl/rgb_window_median_filter.sv
// RGB window median filter, top level. An item with no result goes from CHECK back to
// IDLE; else SCAN makes eight passes over the clipped window (n pixels, at most 49),
// one window pixel a cycle from the line store read port, then DONE; empty goes to DONE.
// Results sit in an output register; the next item is taken meanwhile.
// Reset clears counters and control; the line store is not cleared.
// Depends on rwmf_pkg, rwmf_line_mem, rwmf_rank_sel and the defines header.
`include "rgb_window_median_filter_defines.svh"
module rgb_window_median_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  pixel_red_i,
  input  logic [7:0]  pixel_green_i,
  input  logic [7:0]  pixel_blue_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  median_red_o,
  output logic [7:0]  median_green_o,
  output logic [7:0]  median_blue_o,
  output logic        frame_end_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [10:0] img_w_q;
  logic [12:0] img_h_q;
  logic [1:0]  half_q;

  logic [9:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [12:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic        inc_q, inc_d;

  logic [10:0] w_eff;
  logic [12:0] h_eff, hm1;
  logic [9:0]  wm1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= 11'd1024;
      img_h_q <= 13'd1;
      half_q  <= 2'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rwmf_pkg::RegWidth:  img_w_q <= cfg_data_i[10:0];
        rwmf_pkg::RegHeight: img_h_q <= cfg_data_i;
        rwmf_pkg::RegHalf:   half_q  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (img_w_q == '0) ? 11'd1 :
                 (img_w_q > 11'(rwmf_pkg::MaxWidth)) ? 11'(rwmf_pkg::MaxWidth) : img_w_q;
  assign h_eff = (img_h_q == '0) ? 13'd1 : img_h_q;
  assign hm1   = h_eff - 13'd1;
  assign wm1   = 10'(w_eff - 11'd1);

  logic in_acc, store;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign store      = in_acc && (cmd_i == rwmf_pkg::CmdPixel) && !inc_q;

  // window bounds for the next output
  logic [13:0] rsum;
  logic [10:0] csum;
  logic [12:0] rr, r_lo;
  logic [9:0]  rc, c_lo;
  logic [2:0]  nrows, ncols;
  logic        ready, last, empty;

  assign rsum  = {1'b0, out_row_q} + 14'(half_q);
  assign csum  = {1'b0, out_col_q} + 11'(half_q);
  assign rr    = (rsum > {1'b0, hm1}) ? hm1 : rsum[12:0];
  assign rc    = (csum > {1'b0, wm1}) ? wm1 : csum[9:0];
  assign r_lo  = (out_row_q >= 13'(half_q)) ? out_row_q - 13'(half_q) : '0;
  assign c_lo  = (out_col_q >= 10'(half_q)) ? out_col_q - 10'(half_q) : '0;
  assign nrows = 3'(rr - r_lo) + 3'd1;
  assign ncols = 3'(rc - c_lo) + 3'd1;
  // only after the image shrinks under the output position
  assign empty = (r_lo > rr) || (c_lo > rc);
  assign ready = inc_q || (rr < in_row_q) || ((rr == in_row_q) && (rc < in_col_q));
  assign last  = (out_row_q >= hm1) && (({1'b0, out_col_q} + 11'd1) >= w_eff);

  // scan control
  logic [12:0] r_lo_q, r_hi_q, sr_q, sr_d;
  logic [9:0]  c_lo_q, c_hi_q, sc_q, sc_d;
  logic [rwmf_pkg::CntW-1:0] n_q, n_d;
  logic        iss_q, iss_d, rv_q, rl_q, iss_last;
  logic [2:0]  bit_q, bit_d;
  logic        sel_init;

  assign iss_last = iss_q && (sc_q == c_hi_q) && (sr_q == r_hi_q);

  logic        out_load;
  assign out_load = (state_q == ST_DONE) && (!out_valid_o || !out_stall_i);

  always_comb begin
    state_d   = state_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    inc_d     = inc_q;
    sr_d      = sr_q;
    sc_d      = sc_q;
    iss_d     = iss_q;
    bit_d     = bit_q;
    n_d       = n_q;
    sel_init  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_CHECK;
        end
        if (store) begin
          if ((in_row_q >= hm1) && (({1'b0, in_col_q} + 11'd1) >= w_eff)) begin
            inc_d = 1'b1;
          end else if (({1'b0, in_col_q} + 11'd1) >= w_eff) begin
            in_col_d = '0;
            in_row_d = in_row_q + 13'd1;
          end else begin
            in_col_d = in_col_q + 10'd1;
          end
        end
      end
      ST_CHECK: begin
        if (ready) begin
          sel_init = 1'b1;
          if (empty) begin
            // cleared selectors give a zero median
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
            sr_d    = r_lo;
            sc_d    = c_lo;
            iss_d   = 1'b1;
            bit_d   = 3'd7;
            n_d     = rwmf_pkg::CntW'(nrows) * rwmf_pkg::CntW'(ncols);
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (iss_q) begin
          if (sc_q == c_hi_q) begin
            sc_d = c_lo_q;
            sr_d = sr_q + 13'd1;
          end else begin
            sc_d = sc_q + 10'd1;
          end
          if (iss_last) begin
            iss_d = 1'b0;
          end
        end
        if (rl_q) begin
          if (bit_q == 3'd0) begin
            state_d = ST_DONE;
          end else begin
            bit_d = bit_q - 3'd1;
            sr_d  = r_lo_q;
            sc_d  = c_lo_q;
            iss_d = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
          if (last) begin
            in_col_d  = '0;
            in_row_d  = '0;
            out_col_d = '0;
            out_row_d = '0;
            inc_d     = 1'b0;
          end else if (({1'b0, out_col_q} + 11'd1) >= w_eff) begin
            out_col_d = '0;
            out_row_d = out_row_q + 13'd1;
          end else begin
            out_col_d = out_col_q + 10'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      inc_q     <= 1'b0;
      iss_q     <= 1'b0;
      rv_q      <= 1'b0;
      rl_q      <= 1'b0;
      bit_q     <= '0;
      n_q       <= '0;
    end else begin
      state_q   <= state_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      inc_q     <= inc_d;
      iss_q     <= iss_d;
      rv_q      <= iss_q;
      rl_q      <= iss_last;
      bit_q     <= bit_d;
      n_q       <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sr_q <= sr_d;
    sc_q <= sc_d;
    if (sel_init) begin
      r_lo_q <= r_lo;
      r_hi_q <= rr;
      c_lo_q <= c_lo;
      c_hi_q <= rc;
    end
  end

  logic [rwmf_pkg::PixW-1:0] rdata;

  rwmf_line_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i ({in_row_q[rwmf_pkg::RowSelW-1:0], in_col_q}),
    .wdata_i ({pixel_blue_i, pixel_green_i, pixel_red_i}),
    .raddr_i ({sr_q[rwmf_pkg::RowSelW-1:0], sc_q}),
    .rdata_o (rdata)
  );

  rwmf_pkg::sel_ctl_t sel_ctl;
  assign sel_ctl = '{init: sel_init, bit_idx: bit_q, data_vld: rv_q, data_last: rl_q};

  logic [rwmf_pkg::CntW-1:0] n_now, k_lo, k_hi;
  assign n_now = rwmf_pkg::CntW'(nrows) * rwmf_pkg::CntW'(ncols);
  assign k_lo  = (n_now - 6'd1) >> 1;
  assign k_hi  = n_now >> 1;

  logic [7:0] lo_v [3];
  logic [7:0] hi_v [3];
  logic [7:0] med  [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    rwmf_rank_sel u_lo (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (sel_ctl),
      .rank_i   (k_lo),
      .val_i    (rdata[8*ch +: 8]),
      .result_o (lo_v[ch])
    );
    rwmf_rank_sel u_hi (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (sel_ctl),
      .rank_i   (k_hi),
      .val_i    (rdata[8*ch +: 8]),
      .result_o (hi_v[ch])
    );
    // odd count: both ranks agree, so the mean is the middle value
    assign med[ch] = 8'(({1'b0, lo_v[ch]} + {1'b0, hi_v[ch]}) >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      median_red_o   <= med[0];
      median_green_o <= med[1];
      median_blue_o  <= med[2];
      frame_end_o    <= last;
    end
  end

  `RWMF_ASSERT_IMP(a_busy_stalls, clk_i, rst_ni, state_q != ST_IDLE, in_stall_o)
  `RWMF_ASSERT_IMP(a_last_has_data, clk_i, rst_ni, rl_q, rv_q && state_q == ST_SCAN)
  `RWMF_ASSERT_IMP(a_window_nonempty, clk_i, rst_ni, state_q == ST_SCAN, n_q != '0)
  `RWMF_ASSERT_NXT(a_load_shows, clk_i, rst_ni, out_load, out_valid_o && state_q == ST_IDLE)

endmodule
